// ----- rtl/core/alpha_weighted_mse_accumulator_core_assert.svh -----
// Assertion macros for the alpha weighted MSE accumulator.
// Clocked by clk and disabled during rst of the including module.
`ifndef ALPHA_WEIGHTED_MSE_ACCUMULATOR_CORE_ASSERT_SVH
`define ALPHA_WEIGHTED_MSE_ACCUMULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define AWMSE_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define AWMSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AWMSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AWMSE_ASSERT(lbl, expr, msg)
`define AWMSE_ASSERT_IMPL(lbl, ante, cons, msg)
`define AWMSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/awmse_pkg.sv -----
// Shared widths, constants, types and helpers of the alpha weighted MSE accumulator.
// No dependencies.
`default_nettype none
package awmse_pkg;

  localparam int PIX_W      = 8;
  localparam int COMP_W     = 3;
  localparam int SQ_W       = 18;
  localparam int WPROD_W    = SQ_W + PIX_W;
  localparam int DIST_W     = 18;
  localparam int TOTAL_W    = 43;
  localparam int ERR_W      = 42;
  localparam int CNT_W      = 25;
  localparam int MEAN_W     = 24;
  localparam int NUM_W      = TOTAL_W + 8;
  localparam int DEN_W      = CNT_W + COMP_W;
  localparam int STEP_W     = $clog2(NUM_W + 1);

  localparam logic [CNT_W-1:0]  MAX_PIXELS = CNT_W'(16777216);
  localparam logic [PIX_W-1:0]  ALPHA_FULL = 8'hff;
  localparam logic [COMP_W-1:0] COMP_ONE   = 3'd1;
  localparam logic [COMP_W-1:0] COMP_FULL  = 3'd4;

  // floor(x/255) as (x*RECIP_255) >> RECIP_SHIFT, exact for x below 2^34/251
  localparam int RECIP_SHIFT = 34;
  localparam int RECIP_W     = 27;
  localparam int SCL_W       = WPROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_255 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(ALPHA_FULL) - 64'd1) / 64'(ALPHA_FULL));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_WGT,
    ST_SCL,
    ST_ACC,
    ST_DSET,
    ST_DIV,
    ST_LOAD
  } awmse_state_t;

  typedef struct packed {
    logic load_in;
    logic sq;
    logic wgt;
    logic scl;
    logic acc;
    logic div_start;
    logic div_step;
    logic load_out;
  } awmse_cmd_t;

  typedef struct packed {
    logic last;
    logic div_last;
    logic out_free;
  } awmse_status_t;

  function automatic logic [COMP_W-1:0] eff_comps(input logic [COMP_W-1:0] c);
    logic [COMP_W-1:0] r;
    r = c;
    if (c == '0) r = COMP_ONE;
    else if (c > COMP_FULL) r = COMP_FULL;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/awmse_ctrl.sv -----
// Sequencing state machine of the alpha weighted MSE accumulator.
// Depends on awmse_pkg; drives commands to awmse_dp and reads its status.
`default_nettype none
module awmse_ctrl
  import awmse_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output awmse_cmd_t         cmd,
  input  wire awmse_status_t status
);

  awmse_state_t state;
  awmse_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq     = 1'b1;
        state_next = ST_WGT;
      end
      ST_WGT: begin
        cmd.wgt    = 1'b1;
        state_next = ST_SCL;
      end
      ST_SCL: begin
        cmd.scl    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.last ? ST_DSET : ST_IDLE;
      end
      ST_DSET: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/awmse_dp.sv -----
// Datapath: input capture, squared distance, alpha weighting, accumulation,
// restoring mean division and output register. Depends on awmse_pkg.
`default_nettype none
module awmse_dp
  import awmse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [COMP_W-1:0] components,
  input  wire logic [PIX_W-1:0]  test_c0,
  input  wire logic [PIX_W-1:0]  test_c1,
  input  wire logic [PIX_W-1:0]  test_c2,
  input  wire logic [PIX_W-1:0]  test_c3,
  input  wire logic [PIX_W-1:0]  ref_c0,
  input  wire logic [PIX_W-1:0]  ref_c1,
  input  wire logic [PIX_W-1:0]  ref_c2,
  input  wire logic [PIX_W-1:0]  ref_c3,
  input  wire logic              last_pixel,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [MEAN_W-1:0]      mean_error_q8,
  output logic [ERR_W-1:0]       error_total,
  output logic [CNT_W-1:0]       pixel_total,
  output logic                   overflow,
  input  wire awmse_cmd_t        cmd,
  output awmse_status_t          status
);

  logic [COMP_W-1:0]  comp_reg;
  logic [PIX_W-1:0]   tpix [4];
  logic [PIX_W-1:0]   rpix [4];
  logic               last;
  logic [COMP_W-1:0]  comps;
  logic [SQ_W-1:0]    sqsum;
  logic [SQ_W-1:0]    sqsum_next;
  logic [PIX_W-1:0]   alpha;
  logic [WPROD_W-1:0] wprod;
  logic               weighted;
  logic [DIST_W-1:0]  pix_dist;
  logic [SCL_W-1:0]   scl_prod;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W:0]   total_sum;
  logic [CNT_W-1:0]   count;
  logic               ovf;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   den_next;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W:0]     rem_shift;
  logic               rem_ge;
  logic [STEP_W-1:0]  steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_reg <= COMP_FULL;
    end else if (cfg_valid) begin
      comp_reg <= components;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tpix[0] <= test_c0;
      tpix[1] <= test_c1;
      tpix[2] <= test_c2;
      tpix[3] <= test_c3;
      rpix[0] <= ref_c0;
      rpix[1] <= ref_c1;
      rpix[2] <= ref_c2;
      rpix[3] <= ref_c3;
      last    <= last_pixel;
      comps   <= eff_comps(comp_reg);
    end
  end

  always_comb begin
    logic [PIX_W-1:0]   d;
    logic [2*PIX_W-1:0] sq;
    sqsum_next = '0;
    for (int k = 0; k < 4; k++) begin
      d  = (tpix[k] > rpix[k]) ? (tpix[k] - rpix[k]) : (rpix[k] - tpix[k]);
      sq = (2*PIX_W)'(d) * (2*PIX_W)'(d);
      if (COMP_W'(k) < comps) sqsum_next = sqsum_next + SQ_W'(sq);
    end
  end

  assign scl_prod  = SCL_W'(wprod) * SCL_W'(RECIP_255);
  assign total_sum = {1'b0, total} + (TOTAL_W + 1)'(pix_dist);

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sqsum <= sqsum_next;
      alpha <= (tpix[3] > rpix[3]) ? tpix[3] : rpix[3];
    end
    if (cmd.wgt) begin
      weighted <= (comps == COMP_FULL);
      wprod    <= (comps == COMP_FULL) ? (WPROD_W'(sqsum) * WPROD_W'(alpha))
                                       : WPROD_W'(sqsum);
    end
    if (cmd.scl) begin
      pix_dist <= weighted ? DIST_W'(scl_prod >> RECIP_SHIFT) : DIST_W'(wprod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load_out) begin
      total <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.acc) begin
      if (count >= MAX_PIXELS) begin
        ovf <= 1'b1;
      end else begin
        total <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        count <= count + CNT_W'(1);
      end
    end
  end

  assign den_next  = DEN_W'(count) * DEN_W'(comps);
  assign rem_shift = {rem, num[NUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.div_start) begin
      steps <= STEP_W'(NUM_W);
    end else if (cmd.div_step) begin
      steps <= steps - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num <= {total, 8'b0};
      den <= (den_next == '0) ? DEN_W'(1) : den_next;
      rem <= '0;
    end else if (cmd.div_step) begin
      num <= {num[NUM_W-2:0], rem_ge};
      rem <= rem_ge ? DEN_W'(rem_shift - {1'b0, den}) : DEN_W'(rem_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_error_q8 <= (|num[NUM_W-1:MEAN_W]) ? '1 : num[MEAN_W-1:0];
      error_total   <= total[TOTAL_W-1] ? '1 : total[ERR_W-1:0];
      pixel_total   <= count;
      overflow      <= ovf;
    end
  end

  assign status.last     = last;
  assign status.div_last = (steps == STEP_W'(1));
  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ----- rtl/core/alpha_weighted_mse_accumulator_core.sv -----
// Top level of the alpha weighted MSE accumulator: controller plus datapath.
// Depends on awmse_pkg, awmse_ctrl, awmse_dp and the assertion macro header.
//
//   channel | direction | handshake            | payload
//   cfg     | in        | cfg_valid/cfg_ready  | components
//   in      | in        | in_valid/in_ready    | test_c0..3, ref_c0..3, last_pixel
//   out     | out       | out_valid/out_ready  | mean_error_q8, error_total,
//           |           |                      | pixel_total, overflow
//
// A pixel passes capture, square sum, alpha multiply (four components only),
// reciprocal multiply by 1/255 (weighted pixels only) and accumulate.
// A last pixel adds the divider setup and the bit-serial mean divider, then
// loads the output register (held while the previous result waits).
// Reset is synchronous; components returns to 4, totals and counts clear.
// A waiting result blocks the following image only once its last pixel must load the output.
`default_nettype none
`include "alpha_weighted_mse_accumulator_core_assert.svh"
module alpha_weighted_mse_accumulator_core
  import awmse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [COMP_W-1:0] components,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PIX_W-1:0]  test_c0,
  input  wire logic [PIX_W-1:0]  test_c1,
  input  wire logic [PIX_W-1:0]  test_c2,
  input  wire logic [PIX_W-1:0]  test_c3,
  input  wire logic [PIX_W-1:0]  ref_c0,
  input  wire logic [PIX_W-1:0]  ref_c1,
  input  wire logic [PIX_W-1:0]  ref_c2,
  input  wire logic [PIX_W-1:0]  ref_c3,
  input  wire logic              last_pixel,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [MEAN_W-1:0]      mean_error_q8,
  output logic [ERR_W-1:0]       error_total,
  output logic [CNT_W-1:0]       pixel_total,
  output logic                   overflow
);

  awmse_cmd_t    cmd;
  awmse_status_t status;

  assign cfg_ready = 1'b1;

  awmse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  awmse_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .components    (components),
    .test_c0       (test_c0),
    .test_c1       (test_c1),
    .test_c2       (test_c2),
    .test_c3       (test_c3),
    .ref_c0        (ref_c0),
    .ref_c1        (ref_c1),
    .ref_c2        (ref_c2),
    .ref_c3        (ref_c3),
    .last_pixel    (last_pixel),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .mean_error_q8 (mean_error_q8),
    .error_total   (error_total),
    .pixel_total   (pixel_total),
    .overflow      (overflow),
    .cmd           (cmd),
    .status        (status)
  );

  `AWMSE_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
  `AWMSE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "idle after accept")
  `AWMSE_ASSERT_IMPL(a_count_nonzero, out_valid, pixel_total != '0, "zero pixel count")
  `AWMSE_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid, "load kept out_valid low")

endmodule
`default_nettype wire

// ----- bench/tb_alpha_weighted_mse_accumulator_core.sv -----
// Testbench for alpha_weighted_mse_accumulator_core: directed pixel table, then random images.
// Checks results against typed rows or an in-bench MSE predictor, random idling on both sides.
// Depends on awmse_pkg and the RTL of the core only.
`default_nettype none
module tb_alpha_weighted_mse_accumulator_core
  import awmse_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 1450;
  localparam int DRAIN       = 80;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 1500;
  localparam int STEADY_LO   = 700;
  localparam int STEADY_HI   = 950;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [ERR_W-1:0]  err;
    logic [CNT_W-1:0]  cnt;
    logic              ovf;
  } mse_result_t;

  typedef struct {
    bit                cfg_wr;
    logic [COMP_W-1:0] cfg_val;
    logic [31:0]       tpix;
    logic [31:0]       rpix;
    logic              last;
    bit                typed;
    mse_result_t       want;
  } pixel_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [COMP_W-1:0] components = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  test_c0 = '0, test_c1 = '0, test_c2 = '0, test_c3 = '0;
  logic [PIX_W-1:0]  ref_c0 = '0, ref_c1 = '0, ref_c2 = '0, ref_c3 = '0;
  logic              last_pixel = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MEAN_W-1:0] mean_error_q8;
  logic [ERR_W-1:0]  error_total;
  logic [CNT_W-1:0]  pixel_total;
  logic              overflow;

  // sideband held with the payload: typed expectation of the current row
  bit                row_typed = 1'b0;
  mse_result_t       row_want = '0;

  pixel_row_t        pixel_rows[$];
  mse_result_t       pending_means[$];
  int                errs = 0;
  int                pixels_in = 0;
  int                issued = 0;
  bit                steady = 1'b0;
  bit                holding = 1'b0;

  logic [COMP_W-1:0] comps_reg;
  longint unsigned   img_total;
  longint unsigned   img_pixels;
  bit                img_overflow;

  alpha_weighted_mse_accumulator_core dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .components,
    .in_valid, .in_ready,
    .test_c0, .test_c1, .test_c2, .test_c3,
    .ref_c0, .ref_c1, .ref_c2, .ref_c3,
    .last_pixel,
    .out_valid, .out_ready,
    .mean_error_q8, .error_total, .pixel_total, .overflow
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(input string fld, input longint unsigned got,
                        input longint unsigned want);
    if (errs < 100) begin
      $display("%0t mismatch %s: got %0d want %0d", $realtime, fld, got, want);
    end
    errs++;
  endtask

  task automatic accumulate_pixel(input logic [31:0] t, input logic [31:0] r,
                                  input logic last, output bit done,
                                  output mse_result_t res);
    int n;
    longint unsigned sum, a, b, d, alpha, denom, mean;
    n = (comps_reg == '0) ? 1 : (comps_reg > 3'd4) ? 4 : int'(comps_reg);
    done = 1'b0;
    res = '0;
    if (img_pixels >= longint'(MAX_PIXELS)) begin
      img_overflow = 1'b1;
    end else begin
      sum = 0;
      for (int k = 0; k < n; k++) begin
        a = t[8*k +: 8];
        b = r[8*k +: 8];
        d = (a > b) ? a - b : b - a;
        sum += d * d;
      end
      if (n == 4) begin
        alpha = (t[31:24] > r[31:24]) ? t[31:24] : r[31:24];
        sum = (sum * alpha) / 255;
      end
      img_total += sum;
      if (img_total > (64'd1 << 43) - 1) img_total = (64'd1 << 43) - 1;
      img_pixels++;
    end
    if (last) begin
      denom = img_pixels * longint'(n);
      if (denom == 0) denom = 1;
      mean = (img_total << 8) / denom;
      res.mean = (mean > (64'd1 << 24) - 1) ? '1 : mean[MEAN_W-1:0];
      res.err  = (img_total > (64'd1 << 42) - 1) ? '1 : img_total[ERR_W-1:0];
      res.cnt  = (img_pixels > (64'd1 << 25) - 1) ? '1 : img_pixels[CNT_W-1:0];
      res.ovf  = img_overflow;
      done = 1'b1;
      img_total = 0;
      img_pixels = 0;
      img_overflow = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    mse_result_t got, want, pred;
    bit done;
    if (rst) begin
      comps_reg = COMP_FULL;
      img_total = 0;
      img_pixels = 0;
      img_overflow = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) comps_reg = components;
      if (out_valid && out_ready) begin
        got = '{mean_error_q8, error_total, pixel_total, overflow};
        if (pending_means.size() == 0) begin
          report("unexpected result, mean", got.mean, 0);
        end else begin
          want = pending_means.pop_front();
          if (got.mean !== want.mean) report("mean_error_q8", got.mean, want.mean);
          if (got.err !== want.err) report("error_total", got.err, want.err);
          if (got.cnt !== want.cnt) report("pixel_total", got.cnt, want.cnt);
          if (got.ovf !== want.ovf) report("overflow", got.ovf, want.ovf);
        end
      end
      if (in_valid && in_ready) begin
        accumulate_pixel({test_c3, test_c2, test_c1, test_c0},
                         {ref_c3, ref_c2, ref_c1, ref_c0}, last_pixel, done, pred);
        if (done) pending_means.push_back(row_typed ? row_want : pred);
        pixels_in <= pixels_in + 1;
      end
    end
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && pixels_in >= HOLD_AT) begin
        hold_done = 1'b1;
        holding <= 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        holding <= 1'b0;
      end
      out_ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  task automatic add_row(input bit cw, input logic [COMP_W-1:0] cv,
                         input logic [31:0] t, input logic [31:0] r, input logic l,
                         input bit ty, input logic [MEAN_W-1:0] m,
                         input logic [ERR_W-1:0] e, input logic [CNT_W-1:0] c);
    pixel_row_t row;
    row.cfg_wr = cw;
    row.cfg_val = cv;
    row.tpix = t;
    row.rpix = r;
    row.last = l;
    row.typed = ty;
    row.want = '{m, e, c, 1'b0};
    pixel_rows.push_back(row);
  endtask

  task automatic set_components(input logic [COMP_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    components <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input pixel_row_t row);
    steady <= (issued >= STEADY_LO) && (issued < STEADY_HI);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {test_c3, test_c2, test_c1, test_c0} <= row.tpix;
    {ref_c3, ref_c2, ref_c1, ref_c0} <= row.rpix;
    last_pixel <= row.last;
    row_typed <= row.typed;
    row_want <= row.want;
    do @(posedge clk); while (!in_ready);
    issued++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    pixel_row_t row;
    logic [COMP_W-1:0] cfg_order[8];
    int phase, phase_items, n_img, len, w;
    bit open_end;

    cfg_order = '{3'd6, 3'd0, 3'd3, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4};

    add_row(0, 0, 32'h00000000, 32'h00000000, 1, 1, 0, 0, 1);
    add_row(0, 0, 32'hffffffff, 32'h00000000, 1, 1, 16646400, 260100, 1);
    add_row(0, 0, 32'h00000000, 32'hffffffff, 1, 1, 16646400, 260100, 1);
    add_row(0, 0, 32'h00ffffff, 32'h00000000, 1, 1, 0, 0, 1);
    add_row(0, 0, 32'h80123456, 32'h7f654321, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h01ff00ff, 32'hff00ff00, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'hc0a55a3c, 32'h405aa5c3, 1, 0, 0, 0, 0);
    add_row(1, 0, 32'h5a3c77ff, 32'h00112200, 1, 1, 16646400, 65025, 1);
    add_row(1, 1, 32'hffffff42, 32'h00000042, 1, 1, 0, 0, 1);
    add_row(1, 7, 32'hffffffff, 32'h00000000, 1, 1, 16646400, 260100, 1);
    add_row(1, 2, 32'h00001020, 32'h00003000, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'hffffffff, 32'hffff00ff, 1, 0, 0, 0, 0);
    add_row(1, 3, 32'hff00ff00, 32'h00ff00ff, 1, 1, 16646400, 195075, 1);
    add_row(1, 4, 32'h80402010, 32'h00000000, 0, 0, 0, 0, 0);
    add_row(1, 2, 32'h11223344, 32'h44332211, 1, 0, 0, 0, 0);
    add_row(1, 5, 32'h7f8001fe, 32'h807ffe01, 1, 0, 0, 0, 0);
    add_row(1, 4, 32'hff0000ff, 32'h00000000, 1, 1, 8323200, 130050, 1);
    add_row(0, 0, 32'h10203040, 32'h40302010, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'hfe01fe01, 32'h01fe01fe, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h00000001, 32'h00000000, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'haaaaaaaa, 32'h55555555, 1, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (pixel_rows[i]) begin
      if (pixel_rows[i].cfg_wr) set_components(pixel_rows[i].cfg_val);
      send_pixel(pixel_rows[i]);
    end

    row.cfg_wr = 1'b0;
    row.cfg_val = '0;
    row.typed = 1'b0;
    row.want = '0;
    phase = 0;
    while (issued < TOTAL_ITEMS) begin
      set_components(phase < 8 ? cfg_order[phase] : 3'($urandom_range(7)));
      phase++;
      phase_items = $urandom_range(60, 160);
      n_img = 0;
      while ((n_img < phase_items || holding) && issued < TOTAL_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        open_end = ($urandom_range(2) == 0);
        for (int j = 0; j < len; j++) begin
          for (int k = 0; k < 4; k++) begin
            row.tpix[8*k +: 8] = pick_byte();
            row.rpix[8*k +: 8] = ($urandom_range(1) == 0) ? pick_byte()
                                 : row.tpix[8*k +: 8] + 8'($urandom_range(6)) - 8'd3;
          end
          row.last = (j == len - 1);
          n_img++;
          if (row.last && open_end && n_img >= phase_items && !holding) row.last = 1'b0;
          send_pixel(row);
        end
      end
    end
    row.tpix = 32'($urandom);
    row.rpix = 32'($urandom);
    row.last = 1'b1;
    send_pixel(row);
    in_valid <= 1'b0;

    for (w = 0; w < 20000 && pending_means.size() != 0; w++) @(posedge clk);
    while (pending_means.size() != 0) begin
      row.want = pending_means.pop_front();
      report("missing result, mean", 0, row.want.mean);
    end
    repeat (DRAIN) @(posedge clk);
    if (errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
